// ----- rtl/lom_pkg.sv -----
// Package: book parameters, report codes and shared types of the order matcher.
`default_nettype none
package lom_pkg;
    localparam int BOOK_DEPTH = 16;

    localparam logic [1:0] ST_NEW    = 2'd0;
    localparam logic [1:0] ST_FILL   = 2'd1;
    localparam logic [1:0] ST_PFILL  = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    typedef struct packed {
        logic [23:0] price;
        logic [15:0] qty;
        logic [31:0] id;
    } t_entry;

    // one incoming order request
    typedef struct packed {
        logic        side;
        logic [23:0] limit_price;
        logic [15:0] quantity;
        logic [31:0] order_id;
    } t_order;

    // command broadcast to every cell of one side
    typedef struct packed {
        logic   pop;      // shift toward head, drop entry 0
        logic   ins;      // insert new entry at its priority place
        logic   is_bid;   // ordering rule: bids descend, asks ascend
        logic   dec;      // reduce head quantity
        logic [15:0] dec_qty;
        t_entry      new_e;
    } t_cell_cmd;

    typedef struct packed {
        logic [31:0] order_id;
        logic        side;
        logic [1:0]  status;
        logic [23:0] price;
        logic [15:0] qty;
        logic        last;
    } t_report;
endpackage
`default_nettype wire

// ----- rtl/lom_if.sv -----
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface lom_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/limit_order_matcher.sv -----
// Top level of the price-time priority limit order matcher.
// The first report is loaded in S_MATCH when the order trades, in S_FIN when it only
// rests or is rejected; a zero quantity returns to S_IDLE with no report. Each trade
// passes S_MATCH and S_REST, and S_CHK unless it fills the order; a remainder ends in
// S_FIN. Every step waits while a report stalls, and orders are taken only in S_IDLE.
// The single sequencer walks the opposite head; reset empties both sides.
`default_nettype none
module limit_order_matcher (
    input wire logic i_clk,
    input wire logic i_rst_n,
    lom_if.sink      i_order,
    lom_if.source    o_report
);
    import lom_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_REST  = 3'd2; // resting report of a trade that fills the order; pops an emptied head
    localparam logic [2:0] S_FIN   = 3'd3; // insert remainder (new report if untraded) or reject report
    localparam logic [2:0] S_CHK   = 3'd4; // resting report once the next step is known

    logic [2:0]  r_st, n_st;
    logic        r_side;
    logic [23:0] r_price;
    logic [15:0] r_qty, r_orig;
    logic [31:0] r_id;
    logic        r_ovalid;
    t_report     r_rep;
    // pending resting-side report of the current trade
    t_report     r_rrep;
    logic        r_rpop;

    t_cell_cmd bid_cmd, ask_cmd;
    t_entry    bid_h, ask_h, opp_h;
    logic      bid_e, bid_f, ask_e, ask_f, opp_e, own_f;

    lom_side u_bid (.i_clk, .i_rst_n, .i_cmd(bid_cmd), .o_head(bid_h),
                    .o_empty(bid_e), .o_full(bid_f));
    lom_side u_ask (.i_clk, .i_rst_n, .i_cmd(ask_cmd), .o_head(ask_h),
                    .o_empty(ask_e), .o_full(ask_f));

    assign opp_h = r_side ? bid_h : ask_h;
    assign opp_e = r_side ? bid_e : ask_e;
    assign own_f = r_side ? ask_f : bid_f;

    logic        out_free, crosses;
    logic [15:0] t_q;
    assign out_free = !r_ovalid || o_report.ready;
    assign crosses  = !opp_e && (r_side ? (r_price <= opp_h.price)
                                        : (r_price >= opp_h.price));
    assign t_q = (r_qty < opp_h.qty) ? r_qty : opp_h.qty;

    assign i_order.ready = (r_st == S_IDLE);
    assign o_report.valid = r_ovalid;
    assign o_report.data  = r_rep;

    t_cell_cmd cmd;
    logic      to_opp, to_own;
    t_report   n_rep;
    logic      load;

    always_comb begin
        n_st = r_st;
        cmd = '0;
        cmd.new_e = '{price: r_price, qty: r_qty, id: r_id};
        cmd.is_bid = !r_side;
        to_opp = 1'b0;
        to_own = 1'b0;
        load = 1'b0;
        n_rep = r_rep;
        case (r_st)
            S_IDLE: if (i_order.valid) n_st = S_MATCH;
            S_MATCH: if (out_free) begin
                if (r_qty == 16'd0) n_st = S_IDLE;
                else if (crosses) begin
                    load = 1'b1;
                    n_rep = '{order_id: r_id, side: r_side,
                              status: (r_qty == t_q) ? ST_FILL : ST_PFILL,
                              price: opp_h.price, qty: t_q, last: 1'b0};
                    cmd.dec = 1'b1;
                    cmd.dec_qty = t_q;
                    to_opp = 1'b1;
                    n_st = S_REST;
                end else n_st = S_FIN;
            end
            S_REST: if (out_free) begin
                if (r_rpop) begin
                    cmd.pop = 1'b1;
                    to_opp = 1'b1;
                end
                if (r_qty == 16'd0) begin
                    load = 1'b1;
                    n_rep = r_rrep;
                    n_rep.last = 1'b1;
                    n_st = S_IDLE;
                end else n_st = S_CHK;
            end
            // new head is visible now: the resting report is final only if
            // nothing trades next and the remainder rests silently
            S_CHK: if (out_free) begin
                load = 1'b1;
                n_rep = r_rrep;
                n_rep.last = !crosses && !own_f;
                n_st = crosses ? S_MATCH : S_FIN;
            end
            S_FIN: if (out_free) begin
                if (own_f) begin
                    load = 1'b1;
                    n_rep = '{order_id: r_id, side: r_side, status: ST_REJECT,
                              price: r_price, qty: r_qty, last: 1'b1};
                end else begin
                    cmd.ins = 1'b1;
                    to_own = 1'b1;
                    if (r_qty == r_orig) begin
                        load = 1'b1;
                        n_rep = '{order_id: r_id, side: r_side, status: ST_NEW,
                                  price: r_price, qty: r_orig, last: 1'b1};
                    end
                end
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        bid_cmd = '0;
        ask_cmd = '0;
        if ((to_opp && r_side) || (to_own && !r_side)) bid_cmd = cmd;
        if ((to_opp && !r_side) || (to_own && r_side)) ask_cmd = cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (load) r_ovalid <= 1'b1;
            else if (o_report.ready) r_ovalid <= 1'b0;
        end
        if (load) r_rep <= n_rep;
        if (r_st == S_IDLE && i_order.valid) begin
            r_side  <= i_order.data.side;
            r_price <= i_order.data.limit_price;
            r_qty   <= i_order.data.quantity;
            r_orig  <= i_order.data.quantity;
            r_id    <= i_order.data.order_id;
        end
        if (r_st == S_MATCH && out_free && crosses && r_qty != 16'd0) begin
            r_qty  <= r_qty - t_q;
            r_rpop <= (opp_h.qty == t_q);
            r_rrep <= '{order_id: opp_h.id, side: !r_side,
                        status: (opp_h.qty == t_q) ? ST_FILL : ST_PFILL,
                        price: opp_h.price, qty: t_q, last: 1'b0};
            // last flag of the first report: cannot be final
        end
    end
endmodule
`default_nettype wire

// ----- rtl/lom_cell.sv -----
// One book slot: holds an entry, shifts with neighbors, takes inserts.
`default_nettype none
module lom_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lom_pkg::t_cell_cmd i_cmd,
    input  wire logic              i_is_head,
    input  wire logic              i_occ_prev,   // previous cell occupied
    input  wire logic              i_goes_prev,  // new entry goes before previous cell
    input  wire lom_pkg::t_entry   i_prev,
    input  wire lom_pkg::t_entry   i_next,
    input  wire logic              i_occ_next,
    output lom_pkg::t_entry        o_entry,
    output logic                   o_occ,
    output logic                   o_goes        // new entry would go at or before me
);
    import lom_pkg::*;
    t_entry r_e, n_e;
    logic   r_occ, n_occ;

    // new entry goes in front of this one if it is strictly better or the cell is empty
    always_comb begin
        if (!r_occ) o_goes = 1'b1;
        else if (i_cmd.is_bid) o_goes = i_cmd.new_e.price > r_e.price;
        else o_goes = i_cmd.new_e.price < r_e.price;
    end

    always_comb begin
        n_e = r_e;
        n_occ = r_occ;
        if (i_cmd.pop) begin
            n_e = i_next;
            n_occ = i_occ_next;
        end else if (i_cmd.ins) begin
            if (o_goes) begin
                if (i_is_head || !i_goes_prev) begin
                    n_e = i_cmd.new_e;
                    n_occ = 1'b1;
                end else begin
                    n_e = i_prev;
                    n_occ = i_occ_prev;
                end
            end
        end else if (i_cmd.dec && i_is_head) begin
            n_e.qty = r_e.qty - i_cmd.dec_qty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
        if (!i_rst_n) r_occ <= 1'b0;
        else r_occ <= n_occ;
    end

    assign o_entry = r_e;
    assign o_occ   = r_occ;
endmodule
`default_nettype wire

// ----- rtl/lom_side.sv -----
// One side of the book: a row of cells sorted best first.
`default_nettype none
module lom_side (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lom_pkg::t_cell_cmd i_cmd,
    output lom_pkg::t_entry         o_head,
    output logic                    o_empty,
    output logic                    o_full
);
    import lom_pkg::*;
    t_entry e   [BOOK_DEPTH];
    logic   occ [BOOK_DEPTH];
    logic   goes[BOOK_DEPTH];

    for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
        t_entry prev_e, next_e;
        logic   occ_p, goes_p, occ_n;
        if (g == 0) begin : g_h
            assign prev_e = e[0];
            assign occ_p  = 1'b1;
            assign goes_p = 1'b0;
        end else begin : g_m
            assign prev_e = e[g-1];
            assign occ_p  = occ[g-1];
            assign goes_p = goes[g-1];
        end
        if (g == BOOK_DEPTH - 1) begin : g_t
            assign next_e = e[g];
            assign occ_n  = 1'b0;
        end else begin : g_n
            assign next_e = e[g+1];
            assign occ_n  = occ[g+1];
        end
        lom_cell u_cell (
            .i_clk, .i_rst_n, .i_cmd,
            .i_is_head  (g == 0),
            .i_occ_prev (occ_p),
            .i_goes_prev(goes_p),
            .i_prev     (prev_e),
            .i_next     (next_e),
            .i_occ_next (occ_n),
            .o_entry    (e[g]),
            .o_occ      (occ[g]),
            .o_goes     (goes[g])
        );
    end

    assign o_head  = e[0];
    assign o_empty = !occ[0];
    assign o_full  = occ[BOOK_DEPTH-1];
endmodule
`default_nettype wire

// ----- rtl/lom_checker.sv -----
// Port-level checks of the order matcher and their binding.
`default_nettype none
module lom_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_ord_valid,
    input wire logic       i_ord_ready,
    input wire logic       i_rep_valid,
    input wire logic       i_rep_ready,
    input wire logic       i_rep_last,
    input wire logic [1:0] i_rep_status
);
    import lom_pkg::*;
    // a stalled report holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rep_valid && !i_rep_ready |=> i_rep_valid) else $error("report dropped");
    // new and reject reports always close an order
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rep_valid && (i_rep_status == ST_NEW || i_rep_status == ST_REJECT)
        |-> i_rep_last)
        else $error("new/reject not last");
    // an accepted order is never followed by acceptance in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ord_valid && i_ord_ready |=> !i_ord_ready) else $error("order overlap");
endmodule

bind limit_order_matcher lom_checker u_chk (
    .i_clk, .i_rst_n,
    .i_ord_valid(i_order.valid), .i_ord_ready(i_order.ready),
    .i_rep_valid(o_report.valid), .i_rep_ready(o_report.ready),
    .i_rep_last(o_report.data.last), .i_rep_status(o_report.data.status)
);
`default_nettype wire
